@@ rtl/tag_value_multimap_table_top_macros.svh @@
`ifndef TAG_VALUE_MULTIMAP_TABLE_TOP_MACROS_SVH
`define TAG_VALUE_MULTIMAP_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TVMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TVMT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tvmt_pkg.sv @@
package tvmt_pkg;

    localparam int MODE_W     = 3;
    localparam int TAG_W      = 8;
    localparam int VALUE_W    = 64;
    localparam int INDEX_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    localparam int CAPACITY_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_ADD       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT_ALL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT_TAG = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TAG_AT    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_VALUE_AT  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_NTH_VALUE = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TAG_W-1:0]   tag;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] fallback_value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  result_value;
        logic [TAG_W-1:0]    result_tag;
        logic [COUNT_W-1:0]  result_count;
    } out_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

@@ rtl/tvmt_ram.sv @@
module tvmt_ram #(
    parameter int DEPTH  = tvmt_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  tvmt_pkg::entry_t    wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output tvmt_pkg::entry_t    rdata
);
    import tvmt_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tag_value_multimap_table_top.sv @@
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | tvmt_pkg::in_item_t
// rsp     | out | rsp_valid/rsp_ready  | tvmt_pkg::out_item_t
//
// One item at a time. Add, count all and index reads need no scan.
// Set, count tag, nth value: a scan of the entry RAM through one tag comparator,
// one entry at a time, with an extra move step for each removed entry.
// Reset clears the entry count and the control state; the RAM needs no clearing.
// A result waiting on rsp_ready does not block accepting the next item; that
// item stalls in its last cycle until the output register is free.
module tag_value_multimap_table_top #(
    parameter int CAPACITY = tvmt_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  tvmt_pkg::in_item_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output tvmt_pkg::out_item_t  rsp
);
    import tvmt_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_SCAN_ISSUE = 3'd1;
    localparam logic [2:0] S_SCAN_CMP   = 3'd2;
    localparam logic [2:0] S_MOVE       = 3'd3;
    localparam logic [2:0] S_READ_IDX   = 3'd4;
    localparam logic [2:0] S_APPEND     = 3'd5;
    localparam logic [2:0] S_RESP       = 3'd6;

    logic [2:0]       state_reg, state_next;
    in_item_t         item_reg, item_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] hits_reg, hits_next;
    out_item_t        res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;
    out_item_t        rsp_reg, rsp_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    ram_raddr;
    entry_t           ram_rdata;

    logic             out_free;
    logic             tag_match;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] last_pos;
    logic [CMP_W-1:0] req_idx_w;
    logic [CMP_W-1:0] item_idx_w;
    logic [CMP_W-1:0] count_w;
    logic [CMP_W-1:0] hits_w;

    tvmt_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign tag_match  = (ram_rdata.tag == item_reg.tag);
    assign pos_inc    = pos_reg + CNT_W'(1);
    assign last_pos   = count_reg - CNT_W'(1);
    assign req_idx_w  = CMP_W'(req.index);
    assign item_idx_w = CMP_W'(item_reg.index);
    assign count_w    = CMP_W'(count_reg);
    assign hits_w     = CMP_W'(hits_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        hits_next      = hits_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = '{tag: item_reg.tag, value: item_reg.value};
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    pos_next  = '0;
                    hits_next = '0;
                    unique case (req.mode)
                        MODE_ADD:
                        begin
                            state_next = S_APPEND;
                        end
                        MODE_SET, MODE_COUNT_TAG, MODE_NTH_VALUE:
                        begin
                            state_next = S_SCAN_ISSUE;
                        end
                        MODE_COUNT_ALL:
                        begin
                            res_next   = '{ST_OK, '0, '0, COUNT_W'(count_reg)};
                            state_next = S_RESP;
                        end
                        MODE_TAG_AT, MODE_VALUE_AT:
                        begin
                            if (req_idx_w < count_w)
                            begin
                                ram_raddr  = req_idx_w[AW-1:0];
                                state_next = S_READ_IDX;
                            end
                            else
                            begin
                                res_next   = '{ST_MISS, req.fallback_value, '0,
                                               COUNT_W'(count_reg)};
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            res_next   = '{ST_MISS, req.fallback_value, '0,
                                           COUNT_W'(count_reg)};
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN_ISSUE:
            begin
                if (pos_reg < count_reg)
                begin
                    ram_raddr  = pos_reg[AW-1:0];
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    priority case (item_reg.mode)
                        MODE_SET:
                        begin
                            state_next = S_APPEND;
                        end
                        MODE_COUNT_TAG:
                        begin
                            res_next   = '{ST_OK, '0, '0, COUNT_W'(hits_reg)};
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            res_next   = '{ST_MISS, item_reg.fallback_value, '0,
                                           COUNT_W'(count_reg)};
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN_CMP:
            begin
                if (tag_match && item_reg.mode == MODE_SET)
                begin
                    // fetch the last entry to fill the hole
                    ram_raddr  = last_pos[AW-1:0];
                    state_next = S_MOVE;
                end
                else if (tag_match && item_reg.mode == MODE_NTH_VALUE
                         && hits_w == item_idx_w)
                begin
                    res_next   = '{ST_OK, ram_rdata.value, '0, COUNT_W'(count_reg)};
                    state_next = S_RESP;
                end
                else
                begin
                    if (tag_match)
                    begin
                        hits_next = hits_reg + CNT_W'(1);
                    end
                    pos_next = pos_inc;
                    if (pos_inc < count_reg)
                    begin
                        ram_raddr = pos_inc[AW-1:0];
                    end
                    else
                    begin
                        state_next = S_SCAN_ISSUE;
                    end
                end
            end

            S_MOVE:
            begin
                // slot is checked again after the move
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                count_next = last_pos;
                state_next = S_SCAN_ISSUE;
            end

            S_READ_IDX:
            begin
                res_next   = '{ST_OK,
                               (item_reg.mode == MODE_VALUE_AT) ? ram_rdata.value : '0,
                               ram_rdata.tag, COUNT_W'(count_reg)};
                state_next = S_RESP;
            end

            S_APPEND:
            begin
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    res_next = '{ST_FULL, '0, '0, COUNT_W'(count_reg)};
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    res_next   = '{ST_OK, '0, '0, COUNT_W'(count_reg + CNT_W'(1))};
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            hits_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            hits_reg      <= hits_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

endmodule

@@ rtl/tvmt_checker.sv @@
`include "tag_value_multimap_table_top_macros.svh"

module tvmt_checker #(
    parameter int CAPACITY = tvmt_pkg::CAPACITY_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input tvmt_pkg::in_item_t   req,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input tvmt_pkg::out_item_t  rsp
);
    import tvmt_pkg::*;

    // a stalled result holds
    `TVMT_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp), "rsp dropped or changed while stalled")

    // one item in flight: no accept in the cycle after an accept
    `TVMT_ASSERT_NXT(a_one_in_flight, clk, rst_n, req_valid && req_ready,
        !req_ready, "req_ready high right after an accept")

    // full means the table holds CAPACITY entries
    `TVMT_ASSERT_IMP(a_full_count, clk, rst_n, rsp_valid && rsp.status == ST_FULL,
        rsp.result_count == COUNT_W'(CAPACITY), "full status with wrong count")

    `TVMT_ASSERT_IMP(a_full_zero, clk, rst_n, rsp_valid && rsp.status == ST_FULL,
        rsp.result_value == '0 && rsp.result_tag == '0, "full status with data")

endmodule

bind tag_value_multimap_table_top tvmt_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tvmt_pkg::*;

    localparam int TB_CAP = CAPACITY_DEF;
    localparam logic [MODE_W-1:0] MODE_UNDEF = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD = 400;
    localparam int MAX_GAP = 13;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    in_item_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    out_item_t rsp;

    in_item_t pending_q[$];
    out_item_t expected_q[$];

    // predicted table contents, kept packed at 0 .. tbl_n-1
    logic [TAG_W-1:0] tbl_tag[TB_CAP];
    logic [VALUE_W-1:0] tbl_val[TB_CAP];
    int tbl_n = 0;

    int errors = 0;
    int cycles = 0;
    int send_gap = 0;
    int ready_gap = 0;
    int ready_draw;
    int hold_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    bit quiet = 1'b0;

    tag_value_multimap_table_top #(.CAPACITY(TB_CAP)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #10 clk = ~clk;

    function automatic int draw_gap();
        if (quiet)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic out_item_t predict_table(in_item_t it);
        out_item_t r;
        int pos;
        int hits;
        bit found;
        r = '0;
        r.status = ST_OK;
        case (it.mode)
            MODE_ADD, MODE_SET:
            begin
                if (it.mode == MODE_SET)
                begin
                    // swap-remove: the moved-in entry is checked again
                    pos = 0;
                    while (pos < tbl_n)
                    begin
                        if (tbl_tag[pos] == it.tag)
                        begin
                            tbl_tag[pos] = tbl_tag[tbl_n-1];
                            tbl_val[pos] = tbl_val[tbl_n-1];
                            tbl_n--;
                        end
                        else
                            pos++;
                    end
                end
                if (tbl_n >= TB_CAP)
                    r.status = ST_FULL;
                else
                begin
                    tbl_tag[tbl_n] = it.tag;
                    tbl_val[tbl_n] = it.value;
                    tbl_n++;
                end
                r.result_count = COUNT_W'(tbl_n);
            end
            MODE_COUNT_ALL:
                r.result_count = COUNT_W'(tbl_n);
            MODE_COUNT_TAG:
            begin
                hits = 0;
                for (pos = 0; pos < tbl_n; pos++)
                    if (tbl_tag[pos] == it.tag)
                        hits++;
                r.result_count = COUNT_W'(hits);
            end
            MODE_TAG_AT, MODE_VALUE_AT:
            begin
                r.result_count = COUNT_W'(tbl_n);
                if (int'(it.index) < tbl_n)
                begin
                    r.result_tag = tbl_tag[it.index];
                    if (it.mode == MODE_VALUE_AT)
                        r.result_value = tbl_val[it.index];
                end
                else
                begin
                    r.status = ST_MISS;
                    r.result_value = it.fallback_value;
                end
            end
            MODE_NTH_VALUE:
            begin
                found = 1'b0;
                hits = 0;
                r.result_value = it.fallback_value;
                for (pos = 0; pos < tbl_n && !found; pos++)
                begin
                    if (tbl_tag[pos] == it.tag)
                    begin
                        if (hits == int'(it.index))
                        begin
                            r.result_value = tbl_val[pos];
                            found = 1'b1;
                        end
                        hits++;
                    end
                end
                r.status = found ? ST_OK : ST_MISS;
                r.result_count = COUNT_W'(tbl_n);
            end
            default:
            begin
                r.status = ST_MISS;
                r.result_value = it.fallback_value;
                r.result_count = COUNT_W'(tbl_n);
            end
        endcase
        return r;
    endfunction

    function automatic in_item_t mk_item(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag,
                                         logic [VALUE_W-1:0] value,
                                         logic [INDEX_W-1:0] index,
                                         logic [VALUE_W-1:0] fallback);
        in_item_t it;
        it.mode = mode;
        it.tag = tag;
        it.value = value;
        it.index = index;
        it.fallback_value = fallback;
        return it;
    endfunction

    // small tag pool so duplicates and removals happen often
    function automatic in_item_t rand_item(int add_pct, int set_pct);
        logic [TAG_W-1:0] pool[6] = '{8'h00, 8'h01, 8'h80, 8'hFF, 8'h5A, 8'hA5};
        in_item_t it;
        int r;
        it.value = {$urandom, $urandom};
        it.fallback_value = {$urandom, $urandom};
        it.tag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : pool[$urandom_range(0, 5)];
        r = $urandom_range(0, 99);
        if (r < add_pct)
            it.mode = MODE_ADD;
        else if (r < add_pct + set_pct)
            it.mode = MODE_SET;
        else
        begin
            case ($urandom_range(0, 20))
                0:       it.mode = MODE_UNDEF;
                1, 2, 3: it.mode = MODE_COUNT_ALL;
                4, 5, 6, 7: it.mode = MODE_COUNT_TAG;
                8, 9, 10, 11: it.mode = MODE_TAG_AT;
                12, 13, 14, 15: it.mode = MODE_VALUE_AT;
                default: it.mode = MODE_NTH_VALUE;
            endcase
        end
        if (it.mode == MODE_NTH_VALUE && $urandom_range(0, 4) != 0)
            it.index = INDEX_W'($urandom_range(0, 3));
        else
            it.index = INDEX_W'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic push_random(int n, int add_pct, int set_pct);
        for (int i = 0; i < n; i++)
            pending_q.push_back(rand_item(add_pct, set_pct));
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_q.push_back(predict_table(req));
            if (req_valid && !req_ready)
                ;
            else if (send_gap != 0)
            begin
                req_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_q.size() != 0)
            begin
                req <= pending_q.pop_front();
                req_valid <= 1'b1;
                send_gap <= draw_gap();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            ready_gap <= 0;
            hold_left <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            ready_draw = draw_gap();
            ready_gap <= ready_draw;
            rsp_ready <= (ready_draw == 0);
        end
        else if (ready_gap != 0)
        begin
            ready_gap <= ready_gap - 1;
            rsp_ready <= (ready_gap == 1);
        end
        else
            rsp_ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d value %h tag %h count %0d",
                             rsp.status, rsp.result_value, rsp.result_tag, rsp.result_count);
            end
            else
            begin
                out_item_t want;
                want = expected_q.pop_front();
                if (rsp.status !== want.status || rsp.result_value !== want.result_value
                    || rsp.result_tag !== want.result_tag
                    || rsp.result_count !== want.result_count)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp status %0d value %h tag %h count %0d, got status %0d value %h tag %h count %0d",
                                 want.status, want.result_value, want.result_tag,
                                 want.result_count, rsp.status, rsp.result_value,
                                 rsp.result_tag, rsp.result_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL tag_value_multimap_table_top");
            $finish;
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] ones;
        ones = '1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table: index and nth lookups miss, counts read zero
        pending_q.push_back(mk_item(MODE_COUNT_ALL, 8'h00, '0, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_TAG_AT, 8'h00, '0, 4'h0, ones));
        pending_q.push_back(mk_item(MODE_VALUE_AT, 8'hFF, ones, 4'hF, 64'h0123_4567_89AB_CDEF));
        pending_q.push_back(mk_item(MODE_NTH_VALUE, 8'h00, '0, 4'h0, 64'hFEDC_BA98_7654_3210));
        pending_q.push_back(mk_item(MODE_COUNT_TAG, 8'hFF, '0, 4'hF, ones));
        pending_q.push_back(mk_item(MODE_UNDEF, 8'hFF, ones, 4'hF, 64'hA5A5_5A5A_A5A5_5A5A));
        // duplicates of tag 0 so set must recheck each moved-in entry
        pending_q.push_back(mk_item(MODE_ADD, 8'h00, '0, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_ADD, 8'hFF, ones, 4'hF, ones));
        pending_q.push_back(mk_item(MODE_ADD, 8'h00, 64'h1111_2222_3333_4444, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_ADD, 8'h00, 64'h5555_6666_7777_8888, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_COUNT_TAG, 8'h00, '0, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_NTH_VALUE, 8'h00, '0, 4'h2, ones));
        pending_q.push_back(mk_item(MODE_NTH_VALUE, 8'h00, '0, 4'h3, ones));
        pending_q.push_back(mk_item(MODE_SET, 8'h00, 64'h9999_AAAA_BBBB_CCCC, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_COUNT_ALL, 8'h00, '0, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_VALUE_AT, 8'h00, '0, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_VALUE_AT, 8'h00, '0, 4'h1, '0));
        pending_q.push_back(mk_item(MODE_TAG_AT, 8'h00, '0, 4'h2, ones));
        pending_q.push_back(mk_item(MODE_SET, 8'hFF, 64'h0F0F_0F0F_0F0F_0F0F, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_NTH_VALUE, 8'hFF, '0, 4'h0, ones));
        pending_q.push_back(mk_item(MODE_SET, 8'h42, ones, 4'h0, '0));
        pending_q.push_back(mk_item(MODE_VALUE_AT, 8'h00, '0, 4'h2, '0));
        wait_drained();

        push_random(350, 30, 15);

        // receiver stalls long while the sender keeps offering add-heavy items
        hold_requests++;
        push_random(300, 65, 5);
        wait_drained();

        // back-to-back stretch, churn through set
        quiet = 1'b1;
        push_random(200, 30, 35);
        wait_drained();
        quiet = 1'b0;

        push_random(150, 70, 0);
        push_random(200, 20, 20);
        wait_drained();

        repeat (40) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS tag_value_multimap_table_top");
        else
            $display("FAIL tag_value_multimap_table_top");
        $finish;
    end

endmodule
